### design/gbts_pkg.sv
// Package for the gap buffer text store.
// Beat types, operation and status codes, controller states and the
// command/status bundles between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package gbts_pkg;

   // Fixed field widths
   localparam int FUNC_W = 2;
   localparam int LEN_W  = 11;
   localparam int CHAR_W = 8;
   localparam int STS_W  = 2;

   // Operation codes
   localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] OP_DELETE = 2'd1;
   localparam logic [FUNC_W-1:0] OP_READ   = 2'd2;

   // Status codes
   localparam logic [STS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STS_W-1:0] STS_RANGE = 2'd1;
   localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [LEN_W-1:0]  position;
      logic [CHAR_W-1:0] char_in;
      logic [LEN_W-1:0]  delete_count;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] read_char;
      logic [STS_W-1:0]  status;
      logic [LEN_W-1:0]  text_length;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_MOVE,
      S_DRAIN,
      S_COMMIT,
      S_READ
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic latch;      // capture the request beat
      logic move_step;  // move one character across the gap
      logic commit;     // apply the insert or delete at the gap
      logic load_rsp;   // load the result register
      logic use_rdata;  // result carries the memory read data
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic ins_ok;     // insert in range and not full
      logic del_ok;     // delete start in range
      logic rd_ok;      // read index in range
      logic need_move;  // gap is not at the position yet
      logic move_last;  // next move step lands the gap on the position
   } sts_type;

endpackage

### design/gbts_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module gbts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/gbts_datapath.sv
// Datapath of the gap buffer text store: request register, gap pointers,
// text length, character memory and result register.
// Depends on gbts_pkg and gbts_ram.
`timescale 1ns / 1ps

module gbts_datapath #(
   parameter int CAPACITY = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  gbts_pkg::req_type req_data,
   input  gbts_pkg::cmd_type cmd,
   output gbts_pkg::sts_type sts,
   output gbts_pkg::rsp_type rsp_data
);

   localparam int PW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int LW = gbts_pkg::LEN_W;
   localparam int CW = (PW > LW) ? PW : LW;
   localparam int DW = gbts_pkg::CHAR_W;

   // Request register
   logic [gbts_pkg::FUNC_W-1:0] op_ff;
   logic [LW-1:0]               pos_ff;
   logic [DW-1:0]               ch_ff;
   logic [LW-1:0]               cnt_ff;

   // Gap state
   logic [PW-1:0] gs_ff, gs_in;
   logic [PW-1:0] ge_ff, ge_in;
   logic [PW-1:0] tc_ff, tc_in;

   // Pending move write
   logic          pend_ff;
   logic [AW-1:0] wa_ff, wa_in;

   gbts_pkg::rsp_type rsp_ff;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [DW-1:0] ram_wdata, ram_rdata;

   logic [CW-1:0] pos_w, tc_w, cnt_w;
   logic [PW-1:0] pos_p, avail, cnt_eff, rd_phys;
   logic          is_ins, is_del, is_rd;
   logic          pos_gt_len, pos_ge_len, full, move_left;
   logic [gbts_pkg::STS_W-1:0] status;

   // Capture request beat
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff  <= req_data.func;
         pos_ff <= req_data.position;
         ch_ff  <= req_data.char_in;
         cnt_ff <= req_data.delete_count;
      end
   end

   // Range checks and clamp
   always_comb begin
      pos_w      = CW'(pos_ff);
      tc_w       = CW'(tc_ff);
      cnt_w      = CW'(cnt_ff);
      is_ins     = (op_ff == gbts_pkg::OP_INSERT);
      is_del     = (op_ff == gbts_pkg::OP_DELETE);
      is_rd      = (op_ff == gbts_pkg::OP_READ);
      pos_gt_len = (pos_w > tc_w);
      pos_ge_len = (pos_w >= tc_w);
      full       = (tc_ff == PW'(CAPACITY));
      // only meaningful once the position is known to be in range
      pos_p      = PW'(pos_ff);
      avail      = tc_ff - pos_p;
      cnt_eff    = (cnt_w > CW'(avail)) ? avail : PW'(cnt_ff);
      move_left  = (pos_p < gs_ff);
      rd_phys    = move_left ? pos_p : (ge_ff + (pos_p - gs_ff));
   end

   always_comb begin
      priority if (is_ins && pos_gt_len) begin
         status = gbts_pkg::STS_RANGE;
      end else if (is_ins && full) begin
         status = gbts_pkg::STS_FULL;
      end else if ((is_del || is_rd) && pos_ge_len) begin
         status = gbts_pkg::STS_RANGE;
      end else begin
         status = gbts_pkg::STS_OK;
      end
   end

   always_comb begin
      sts.ins_ok    = is_ins && !pos_gt_len && !full;
      sts.del_ok    = is_del && !pos_ge_len;
      sts.rd_ok     = is_rd && !pos_ge_len;
      sts.need_move = (pos_p != gs_ff);
      sts.move_last = move_left ? ((gs_ff - PW'(1)) == pos_p)
                                : ((gs_ff + PW'(1)) == pos_p);
   end

   // Memory port selection
   always_comb begin
      ram_we    = pend_ff || (cmd.commit && sts.ins_ok);
      ram_waddr = pend_ff ? wa_ff : AW'(gs_ff);
      ram_wdata = pend_ff ? ram_rdata : ch_ff;
      if (cmd.move_step) begin
         ram_raddr = move_left ? AW'(gs_ff - PW'(1)) : AW'(ge_ff);
      end else begin
         ram_raddr = AW'(rd_phys);
      end
   end

   // Pointer and length update
   always_comb begin
      gs_in = gs_ff;
      ge_in = ge_ff;
      tc_in = tc_ff;
      wa_in = wa_ff;
      if (cmd.move_step) begin
         if (move_left) begin
            wa_in = AW'(ge_ff - PW'(1));
            gs_in = gs_ff - PW'(1);
            ge_in = ge_ff - PW'(1);
         end else begin
            wa_in = AW'(gs_ff);
            gs_in = gs_ff + PW'(1);
            ge_in = ge_ff + PW'(1);
         end
      end else if (cmd.commit && sts.ins_ok) begin
         gs_in = gs_ff + PW'(1);
         tc_in = tc_ff + PW'(1);
      end else if (cmd.commit && sts.del_ok) begin
         ge_in = ge_ff + cnt_eff;
         tc_in = tc_ff - cnt_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gs_ff   <= '0;
         ge_ff   <= PW'(CAPACITY);
         tc_ff   <= '0;
         pend_ff <= 1'b0;
      end else begin
         gs_ff   <= gs_in;
         ge_ff   <= ge_in;
         tc_ff   <= tc_in;
         pend_ff <= cmd.move_step;
      end
   end

   always_ff @(posedge clock) begin
      wa_ff <= wa_in;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.read_char   <= cmd.use_rdata ? ram_rdata : '0;
         rsp_ff.status      <= status;
         rsp_ff.text_length <= LW'(tc_in);
      end
   end

   assign rsp_data = rsp_ff;

   gbts_ram #(
      .WIDTH(DW),
      .DEPTH(CAPACITY)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

endmodule

### design/gbts_controller.sv
// Controller of the gap buffer text store: sequences accept, gap move,
// commit and read, and owns the handshake control.
// Depends on gbts_pkg.
`timescale 1ns / 1ps

module gbts_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  gbts_pkg::sts_type sts,
   output gbts_pkg::cmd_type cmd
);

   gbts_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free;

   // a new beat is taken only when the result register will be empty
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == gbts_pkg::S_IDLE) && rsp_free);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gbts_pkg::S_IDLE: begin
            if (req_valid && !req_stall) state_in = gbts_pkg::S_EXEC;
         end
         gbts_pkg::S_EXEC: begin
            if (sts.rd_ok) begin
               state_in = gbts_pkg::S_READ;
            end else if ((sts.ins_ok || sts.del_ok) && sts.need_move) begin
               state_in = gbts_pkg::S_MOVE;
            end else begin
               state_in = gbts_pkg::S_IDLE;
            end
         end
         gbts_pkg::S_MOVE: begin
            if (sts.move_last) state_in = gbts_pkg::S_DRAIN;
         end
         gbts_pkg::S_DRAIN:  state_in = gbts_pkg::S_COMMIT;
         gbts_pkg::S_COMMIT: state_in = gbts_pkg::S_IDLE;
         gbts_pkg::S_READ:   state_in = gbts_pkg::S_IDLE;
         default:            state_in = gbts_pkg::S_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         gbts_pkg::S_IDLE: begin
            cmd.latch = req_valid && !req_stall;
         end
         gbts_pkg::S_EXEC: begin
            // a read or a gap move issues nothing here
            if (!sts.rd_ok && !((sts.ins_ok || sts.del_ok) && sts.need_move)) begin
               // in place commit, or an error / unused code
               cmd.commit   = sts.ins_ok || sts.del_ok;
               cmd.load_rsp = 1'b1;
            end
         end
         gbts_pkg::S_MOVE: begin
            cmd.move_step = 1'b1;
         end
         gbts_pkg::S_DRAIN: begin
            cmd = '0;
         end
         gbts_pkg::S_COMMIT: begin
            cmd.commit   = 1'b1;
            cmd.load_rsp = 1'b1;
         end
         gbts_pkg::S_READ: begin
            cmd.load_rsp  = 1'b1;
            cmd.use_rdata = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

   // Result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gbts_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### design/gap_buffer_text_store.sv
// Gap buffer text store. One request beat at a time: a read passes the
// execute and read states; an insert or delete with the gap already at its
// position, and an error or unused code, pass the execute state only. When
// the gap must move, the controller steps it one character at a time on the
// memory's single read and write ports, then drains the last move write and
// commits. A result stays in its output register until taken; a new request
// is accepted once that register is empty or being emptied. The character
// memory is not cleared after reset and needs no init pass.
// Depends on gbts_pkg, gbts_controller and gbts_datapath.
`timescale 1ns / 1ps

module gap_buffer_text_store #(
   parameter int CAPACITY = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gbts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gbts_pkg::rsp_type rsp_data
);

   gbts_pkg::cmd_type cmd;
   gbts_pkg::sts_type sts;

   gbts_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   gbts_datapath #(
      .CAPACITY(CAPACITY)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_data(req_data),
      .cmd     (cmd),
      .sts     (sts),
      .rsp_data(rsp_data)
   );

   // result register is never overwritten while a beat is still held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !rsp_valid)
      else $error("result loaded while previous beat pending");

   // one request in flight: stall right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while busy");

   // commit only for a valid insert or delete
   a_commit_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (sts.ins_ok || sts.del_ok))
      else $error("commit without a valid edit");

   // a move step never coincides with commit or result load
   a_move_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.move_step |-> (!cmd.commit && !cmd.load_rsp && !req_valid || req_stall))
      else $error("move step overlaps another operation");

endmodule

### sim/tb.sv
// Testbench for gap_buffer_text_store: directed edits, random edit streams and a
// fill to capacity, the streams under changing idle and stall pressure, checked beat
// by beat against a logical text image. Depends on gbts_pkg and the store RTL.
`timescale 1ns / 1ps

module tb;

   localparam int FUNC_BITS = gbts_pkg::FUNC_W;
   localparam int LEN_BITS  = gbts_pkg::LEN_W;
   localparam int CHAR_BITS = gbts_pkg::CHAR_W;
   localparam int TEXT_CAP = 1024;
   localparam logic [FUNC_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int MIX_ITEMS = 65;
   localparam int MIX_MAX_LEN = 96;
   localparam int MAX_FIELD = 2047;

   typedef struct {
      gbts_pkg::req_type beat;
      int unsigned       phase;
      bit                hold;
   } edit_item_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   gbts_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   gbts_pkg::rsp_type rsp_data;

   edit_item_type        edit_queue[$];
   gbts_pkg::rsp_type    pending_answers[$];
   logic [CHAR_BITS-1:0] text_image [TEXT_CAP];
   int unsigned          text_len = 0;
   int unsigned          gen_len = 0;
   int unsigned          gen_phase = 0;
   int unsigned          live_phase = 0;
   int unsigned          fault_count = 0;
   // per phase: quiet, sender idle, receiver stall, both
   int unsigned          send_gap_pct [4] = '{0, 76, 0, 23};
   int unsigned          recv_stall_pct [4] = '{0, 0, 76, 23};

   gap_buffer_text_store #(.CAPACITY(TEXT_CAP)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #6 clock = ~clock;

   // Apply one edit to the logical text and return the answer it should produce
   function automatic gbts_pkg::rsp_type apply_text_edit(gbts_pkg::req_type r);
      gbts_pkg::rsp_type a;
      int unsigned       pos;
      int unsigned       cnt;
      int unsigned       k;
      pos = 32'(r.position);
      cnt = 32'(r.delete_count);
      a = '0;
      a.status = gbts_pkg::STS_OK;
      case (r.func)
         gbts_pkg::OP_INSERT: begin
            if (pos > text_len) begin
               a.status = gbts_pkg::STS_RANGE;
            end else if (text_len >= TEXT_CAP) begin
               a.status = gbts_pkg::STS_FULL;
            end else begin
               for (k = text_len; k > pos; k--) text_image[k] = text_image[k-1];
               text_image[pos] = r.char_in;
               text_len++;
            end
         end
         gbts_pkg::OP_DELETE: begin
            if (pos >= text_len) begin
               a.status = gbts_pkg::STS_RANGE;
            end else begin
               // clamp the run to the end of the text
               if (cnt > text_len - pos) cnt = text_len - pos;
               for (k = pos; k + cnt < text_len; k++) text_image[k] = text_image[k+cnt];
               text_len -= cnt;
            end
         end
         gbts_pkg::OP_READ: begin
            if (pos >= text_len) a.status = gbts_pkg::STS_RANGE;
            else a.read_char = text_image[pos];
         end
         default: ;
      endcase
      a.text_length = LEN_BITS'(text_len);
      return a;
   endfunction

   // Queue one edit beat; track the length so later beats can stay well formed
   function automatic void queue_beat(logic [FUNC_BITS-1:0] f, int unsigned pos,
                                      logic [CHAR_BITS-1:0] ch, int unsigned cnt,
                                      bit hold);
      edit_item_type it;
      it.beat.func = f;
      it.beat.position = LEN_BITS'(pos);
      it.beat.char_in = ch;
      it.beat.delete_count = LEN_BITS'(cnt);
      it.phase = gen_phase;
      it.hold = hold;
      case (f)
         gbts_pkg::OP_INSERT: if (pos <= gen_len && gen_len < TEXT_CAP) gen_len++;
         gbts_pkg::OP_DELETE:
            if (pos < gen_len) gen_len -= (cnt > gen_len - pos) ? gen_len - pos : cnt;
         default: ;
      endcase
      edit_queue.push_back(it);
   endfunction

   // Request driver: predicts each taken beat, then offers the next one
   always @(posedge clock) begin : driver
      bit go;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_answers.push_back(apply_text_edit(req_data));
         end
         if (!req_valid || !req_stall) begin
            go = edit_queue.size() != 0;
            // a held beat waits until every answer is back
            if (go && edit_queue[0].hold) go = pending_answers.size() == 0;
            if (go && $urandom_range(99) < send_gap_pct[edit_queue[0].phase]) go = 1'b0;
            if (go) begin
               req_data <= edit_queue[0].beat;
               live_phase <= edit_queue[0].phase;
               void'(edit_queue.pop_front());
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each taken beat with the oldest expected answer
   always @(posedge clock) begin : monitor
      gbts_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               $error("result beat with no answer pending: %h", rsp_data);
               fault_count++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_data.read_char !== want.read_char) begin
                  $error("read_char: expected %0h, got %0h", want.read_char, rsp_data.read_char);
                  fault_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  fault_count++;
               end
               if (rsp_data.text_length !== want.text_length) begin
                  $error("text_length: expected %0d, got %0d",
                         want.text_length, rsp_data.text_length);
                  fault_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct[live_phase]);
      end
   end

   // Stimulus and end of run
   initial begin : stimulus
      int unsigned roll;
      int unsigned pos;
      int unsigned cnt;
      int unsigned ph;
      int unsigned n;

      // directed: empty text, ends, middle, clamps, unused code
      gen_phase = 0;
      queue_beat(gbts_pkg::OP_READ, 0, 8'h00, 0, 1'b0);
      queue_beat(gbts_pkg::OP_DELETE, 0, 8'h00, 5, 1'b0);
      queue_beat(gbts_pkg::OP_INSERT, 1, 8'h11, 0, 1'b0);
      queue_beat(gbts_pkg::OP_INSERT, 0, 8'hFF, 0, 1'b0);
      queue_beat(gbts_pkg::OP_INSERT, 0, 8'h00, 0, 1'b0);
      queue_beat(gbts_pkg::OP_INSERT, 2, 8'hA5, 0, 1'b0);
      queue_beat(gbts_pkg::OP_INSERT, 1, 8'h5A, 0, 1'b0);
      for (n = 0; n < 4; n++) queue_beat(gbts_pkg::OP_READ, n, 8'h00, 0, 1'b0);
      queue_beat(gbts_pkg::OP_READ, 4, 8'h00, 0, 1'b0);
      queue_beat(gbts_pkg::OP_READ, MAX_FIELD, 8'hFF, MAX_FIELD, 1'b0);
      queue_beat(gbts_pkg::OP_INSERT, MAX_FIELD, 8'hFF, MAX_FIELD, 1'b0);
      queue_beat(gbts_pkg::OP_DELETE, 4, 8'h00, 1, 1'b0);
      queue_beat(gbts_pkg::OP_DELETE, 1, 8'h00, 0, 1'b0);
      queue_beat(gbts_pkg::OP_DELETE, MAX_FIELD, 8'hFF, MAX_FIELD, 1'b0);
      queue_beat(OP_UNUSED, MAX_FIELD, 8'hFF, MAX_FIELD, 1'b0);
      queue_beat(gbts_pkg::OP_DELETE, 2, 8'h00, MAX_FIELD, 1'b0);
      queue_beat(gbts_pkg::OP_READ, 1, 8'h00, 0, 1'b0);
      queue_beat(gbts_pkg::OP_READ, 0, 8'h00, 0, 1'b0);
      queue_beat(gbts_pkg::OP_DELETE, 0, 8'h00, 2, 1'b0);
      queue_beat(gbts_pkg::OP_READ, 0, 8'h00, 0, 1'b0);

      for (ph = 0; ph < 4; ph++) begin
         gen_phase = ph;
         // each phase opens with a beat that waits for a drained store
         queue_beat(gbts_pkg::OP_READ, 0, 8'h00, 0, 1'b1);
         for (n = 0; n < MIX_ITEMS; n++) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
               // noise: any code, any field value
               queue_beat(FUNC_BITS'($urandom_range(3)), $urandom_range(MAX_FIELD),
                          CHAR_BITS'($urandom_range(255)), $urandom_range(MAX_FIELD), 1'b0);
            end else if ((roll < 50 && gen_len < MIX_MAX_LEN) || gen_len == 0) begin
               queue_beat(gbts_pkg::OP_INSERT, $urandom_range(gen_len),
                          CHAR_BITS'($urandom_range(255)), $urandom_range(MAX_FIELD), 1'b0);
            end else if (roll < 70 || gen_len >= MIX_MAX_LEN) begin
               pos = $urandom_range(gen_len - 1);
               case ($urandom_range(7))
                  0: cnt = 0;
                  1: cnt = $urandom_range(MAX_FIELD);
                  default: cnt = $urandom_range(4, 1);
               endcase
               queue_beat(gbts_pkg::OP_DELETE, pos, CHAR_BITS'($urandom_range(255)), cnt, 1'b0);
            end else begin
               queue_beat(gbts_pkg::OP_READ, $urandom_range(gen_len - 1),
                          CHAR_BITS'($urandom_range(255)), $urandom_range(MAX_FIELD), 1'b0);
            end
         end

         if (ph == 0) begin
            // fill to capacity with appends, sampling the text as it grows
            while (gen_len < TEXT_CAP) begin
               if ($urandom_range(7) == 0) begin
                  queue_beat(gbts_pkg::OP_READ, $urandom_range(gen_len - 1), 8'h00, 0, 1'b0);
               end else begin
                  queue_beat(gbts_pkg::OP_INSERT, gen_len, CHAR_BITS'($urandom_range(255)),
                             0, 1'b0);
               end
            end
            queue_beat(gbts_pkg::OP_INSERT, TEXT_CAP, 8'h77, 0, 1'b0);
            queue_beat(gbts_pkg::OP_INSERT, TEXT_CAP + 1, 8'h77, 0, 1'b0);
            queue_beat(gbts_pkg::OP_INSERT, 0, 8'h77, 0, 1'b0);
            queue_beat(gbts_pkg::OP_READ, TEXT_CAP - 1, 8'h00, 0, 1'b0);
            queue_beat(gbts_pkg::OP_READ, TEXT_CAP, 8'h00, 0, 1'b0);
            queue_beat(gbts_pkg::OP_DELETE, TEXT_CAP - 1, 8'h00, 1, 1'b0);
            queue_beat(gbts_pkg::OP_INSERT, 500, CHAR_BITS'($urandom_range(255)), 0, 1'b0);
            queue_beat(gbts_pkg::OP_READ, 500, 8'h00, 0, 1'b0);
            queue_beat(gbts_pkg::OP_INSERT, 0, CHAR_BITS'($urandom_range(255)), 0, 1'b0);
            queue_beat(gbts_pkg::OP_READ, TEXT_CAP - 1, 8'h00, 0, 1'b0);
            queue_beat(gbts_pkg::OP_DELETE, 40, 8'h00, MAX_FIELD, 1'b0);
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // drain: all beats sent, all answers back, then a short quiet tail
      while (edit_queue.size() != 0 || req_valid) @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (fault_count == 0) begin
         $display("** gap_buffer_text_store: PASSED **");
      end else begin
         $display("** gap_buffer_text_store: FAILED **");
      end
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #40_000_000;
      $display("** gap_buffer_text_store: FAILED **");
      $finish;
   end

endmodule

### gap_buffer_text_store.f
design/gbts_pkg.sv
design/gbts_ram.sv
design/gbts_datapath.sv
design/gbts_controller.sv
design/gap_buffer_text_store.sv
sim/tb.sv
